@@ rtl/pooled_sorted_linked_list_assert.svh @@
// Assertion macros for the pooled sorted linked list.
// Used by the top level; no other dependencies.
`ifndef POOLED_SORTED_LINKED_LIST_ASSERT_SVH
`define POOLED_SORTED_LINKED_LIST_ASSERT_SVH
// implication checked on every clock edge outside reset
`define PSLL_ASSERT_IMP(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// implication whose consequent is checked in the next cycle
`define PSLL_ASSERT_NXT(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

@@ rtl/psll_pkg.sv @@
// Package for the pooled sorted linked list: sizes, request codes, payload structs.
// No dependencies.
`timescale 1ns / 1ps
package psll_pkg;
   localparam int POOL_SIZE = 64;
   localparam int IDX_W = $clog2(POOL_SIZE);
   localparam int HW = 7;
   localparam logic [HW-1:0] NIL = HW'(POOL_SIZE);

   typedef enum logic [2:0] {
      REQ_FRONT = 3'd0, REQ_BACK = 3'd1, REQ_BEFORE = 3'd2,
      REQ_SORTED = 3'd3, REQ_REMOVE = 3'd4, REQ_REBUILD = 3'd5
   } req_code_type;

   typedef struct packed {
      logic [2:0] req_type;
      logic [6:0] node;
      logic signed [31:0] priority_req;
      logic signed [31:0] value;
   } req_type_type;

   typedef struct packed {
      logic [6:0] node_out;
      logic ok;
      logic signed [31:0] value_out;
   } rsp_type;
endpackage

@@ rtl/psll_ram.sv @@
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module psll_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic clock,
   input  logic we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule

@@ rtl/pooled_sorted_linked_list.sv @@
// Pooled sorted linked list: doubly linked 64-node pool with a LIFO free chain; uses psll_pkg,
// psll_ram and pooled_sorted_linked_list_assert.svh.
// A sorted insert walks the list from the head, one node at a time; rebuild reruns the pool pass.
// One request at a time: busy until the strobe cycle, where the next start is taken;
// the receiver cannot stall. Synchronous reset runs the pool pass before start is taken.
`timescale 1ns / 1ps
`include "pooled_sorted_linked_list_assert.svh"
module pooled_sorted_linked_list (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  psll_pkg::req_type_type req_data,
   input  logic csr_we,
   input  logic [6:0] csr_wdata,
   output logic rsp_valid,
   output psll_pkg::rsp_type rsp_data
);
   import psll_pkg::*;

   typedef enum logic [4:0] {
      S_BUILD, S_IDLE, S_DECODE, S_SORT_RD, S_SORT_WT, S_SORT_CMP,
      S_CHK_RD, S_CHK_WT, S_CHK, S_TAKE_RD, S_TAKE_WT, S_TAKE,
      S_LINK_W1, S_LINK_W2, S_LINK_W3, S_REM_WT, S_REM_W1, S_REM_W2,
      S_DONE
   } state_type;

   state_type state_ff;
   logic [6:0] cfg_ff;
   logic [6:0] head_ff, tail_ff, free_ff;
   logic [POOL_SIZE-1:0] inl_ff;
   req_type_type req_ff;
   logic [6:0] cur_ff, tgt_ff, newn_ff, pv_ff, cnt_ff;
   logic mode_back_ff; // attach at back rather than before tgt
   rsp_type rsp_ff;
   logic rsp_v_ff;

   // node tables: next, prev, priority, value
   logic nl_we, pl_we, pr_we, vl_we;
   logic [IDX_W-1:0] nl_wa, pl_wa, pr_wa, vl_wa, rd_a;
   logic [6:0] nl_wd, pl_wd, nl_rd, pl_rd;
   logic [31:0] pr_rd, vl_rd;
   logic [31:0] pr_wd;

   // only a sorted insert keeps its key; the other inserts store priority 0
   assign pr_wd = (req_ff.req_type == REQ_SORTED) ? req_ff.priority_req : '0;

   psll_ram #(.WIDTH(7), .DEPTH(POOL_SIZE)) u_next (.clock, .we(nl_we), .waddr(nl_wa),
      .wdata(nl_wd), .raddr(rd_a), .rdata(nl_rd));
   psll_ram #(.WIDTH(7), .DEPTH(POOL_SIZE)) u_prev (.clock, .we(pl_we), .waddr(pl_wa),
      .wdata(pl_wd), .raddr(rd_a), .rdata(pl_rd));
   psll_ram #(.WIDTH(32), .DEPTH(POOL_SIZE)) u_prio (.clock, .we(pr_we), .waddr(pr_wa),
      .wdata(pr_wd), .raddr(rd_a), .rdata(pr_rd));
   psll_ram #(.WIDTH(32), .DEPTH(POOL_SIZE)) u_val (.clock, .we(vl_we), .waddr(vl_wa),
      .wdata(req_ff.value), .raddr(rd_a), .rdata(vl_rd));

   logic [6:0] lim;
   assign lim = (cfg_ff > NIL) ? NIL : cfg_ff;
   logic tgt_ok;
   assign tgt_ok = (tgt_ff < NIL) && inl_ff[tgt_ff[IDX_W-1:0]];
   // compare unit for the sorted walk: stored priority >= key (signed)
   logic ge;
   assign ge = $signed(pr_rd) >= req_ff.priority_req;

   // table write and read address steering
   always_comb begin
      nl_we = 1'b0; pl_we = 1'b0; pr_we = 1'b0; vl_we = 1'b0;
      nl_wa = newn_ff[IDX_W-1:0]; pl_wa = newn_ff[IDX_W-1:0];
      pr_wa = newn_ff[IDX_W-1:0]; vl_wa = newn_ff[IDX_W-1:0];
      nl_wd = NIL; pl_wd = NIL;
      rd_a = cur_ff[IDX_W-1:0];
      unique case (state_ff)
         S_BUILD: begin
            nl_we = (cnt_ff < lim);
            nl_wa = cnt_ff[IDX_W-1:0];
            nl_wd = (cnt_ff == 7'd0) ? NIL : cnt_ff - 7'd1;
         end
         S_LINK_W1: begin
            // new node's own links and payload
            nl_we = 1'b1; pl_we = 1'b1; pr_we = 1'b1; vl_we = 1'b1;
            if (mode_back_ff) begin
               nl_wd = NIL; pl_wd = tail_ff;
            end else begin
               nl_wd = tgt_ff; pl_wd = pv_ff;
            end
         end
         S_LINK_W2: begin
            // neighbour after the new node
            if (!mode_back_ff) begin
               pl_we = 1'b1; pl_wa = tgt_ff[IDX_W-1:0]; pl_wd = newn_ff;
            end
         end
         S_LINK_W3: begin
            // neighbour before the new node
            if (mode_back_ff) begin
               nl_we = (tail_ff != NIL); nl_wa = tail_ff[IDX_W-1:0]; nl_wd = newn_ff;
            end else begin
               nl_we = (pv_ff != NIL); nl_wa = pv_ff[IDX_W-1:0]; nl_wd = newn_ff;
            end
         end
         S_REM_W1: begin
            pl_we = (nl_rd != NIL); pl_wa = nl_rd[IDX_W-1:0]; pl_wd = pl_rd;
            nl_we = (pl_rd != NIL); nl_wa = pl_rd[IDX_W-1:0]; nl_wd = nl_rd;
         end
         S_REM_W2: begin
            nl_we = 1'b1; nl_wa = tgt_ff[IDX_W-1:0]; nl_wd = free_ff;
         end
         S_TAKE_RD, S_TAKE_WT: rd_a = free_ff[IDX_W-1:0];
         S_CHK_RD, S_CHK_WT, S_DECODE, S_REM_WT: rd_a = tgt_ff[IDX_W-1:0];
         default: ;
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_BUILD;
         cfg_ff <= 7'd64;
         cnt_ff <= '0;
         inl_ff <= '0;
         head_ff <= NIL; tail_ff <= NIL; free_ff <= NIL;
         req_ff <= '0;
         rsp_ff <= '{node_out: NIL, ok: 1'b0, value_out: '0};
         rsp_v_ff <= 1'b0;
      end else begin
         if (csr_we) cfg_ff <= csr_wdata;
         rsp_v_ff <= (state_ff == S_DONE);
         unique case (state_ff)
            S_BUILD: begin
               if (cnt_ff < lim) free_ff <= cnt_ff;
               if (cnt_ff == NIL - 7'd1) state_ff <= req_ff.req_type == REQ_REBUILD
                  && rsp_ff.ok ? S_DONE : S_IDLE;
               cnt_ff <= cnt_ff + 7'd1;
            end
            S_IDLE: begin
               rsp_ff <= '{node_out: NIL, ok: 1'b0, value_out: '0};
               req_ff <= req_data;
               tgt_ff <= req_data.node;
               cur_ff <= head_ff;
               if (start) state_ff <= S_DECODE;
            end
            S_DECODE: begin
               unique case (req_ff.req_type)
                  REQ_FRONT: begin tgt_ff <= head_ff; pv_ff <= NIL;
                     mode_back_ff <= (head_ff == NIL); state_ff <= S_TAKE_RD; end
                  REQ_BACK: begin mode_back_ff <= 1'b1; state_ff <= S_TAKE_RD; end
                  REQ_BEFORE: begin mode_back_ff <= 1'b0; state_ff <= S_CHK_RD; end
                  REQ_SORTED: begin
                     mode_back_ff <= 1'b0;
                     cnt_ff <= '0;
                     state_ff <= S_SORT_RD;
                  end
                  REQ_REMOVE: state_ff <= tgt_ok ? S_REM_WT : S_DONE;
                  REQ_REBUILD: begin
                     head_ff <= NIL; tail_ff <= NIL; free_ff <= NIL;
                     inl_ff <= '0; cnt_ff <= '0; rsp_ff.ok <= 1'b1;
                     state_ff <= S_BUILD;
                  end
                  default: state_ff <= S_DONE;
               endcase
            end
            S_SORT_RD: begin
               if (cur_ff == NIL || cnt_ff == NIL) begin
                  mode_back_ff <= 1'b1; state_ff <= S_TAKE_RD;
               end else state_ff <= S_SORT_WT;
            end
            S_SORT_WT: state_ff <= S_SORT_CMP;
            S_SORT_CMP: begin
               if (ge) begin
                  tgt_ff <= cur_ff; pv_ff <= pl_rd; state_ff <= S_TAKE_RD;
               end else begin
                  cur_ff <= nl_rd; cnt_ff <= cnt_ff + 7'd1; state_ff <= S_SORT_RD;
               end
            end
            S_CHK_RD: state_ff <= S_CHK_WT;
            S_CHK_WT: state_ff <= S_CHK;
            S_CHK: begin
               if (tgt_ok) pv_ff <= pl_rd;
               else begin
                  tgt_ff <= head_ff; pv_ff <= NIL; mode_back_ff <= (head_ff == NIL);
               end
               state_ff <= S_TAKE_RD;
            end
            S_TAKE_RD: state_ff <= (free_ff == NIL) ? S_DONE : S_TAKE_WT;
            S_TAKE_WT: state_ff <= S_TAKE;
            S_TAKE: begin
               newn_ff <= free_ff; free_ff <= nl_rd; state_ff <= S_LINK_W1;
            end
            S_LINK_W1: state_ff <= S_LINK_W2;
            S_LINK_W2: state_ff <= S_LINK_W3;
            S_LINK_W3: begin
               if (mode_back_ff) begin
                  if (tail_ff == NIL) head_ff <= newn_ff;
                  tail_ff <= newn_ff;
               end else if (pv_ff == NIL) head_ff <= newn_ff;
               inl_ff[newn_ff[IDX_W-1:0]] <= 1'b1;
               rsp_ff.node_out <= newn_ff; rsp_ff.ok <= 1'b1;
               state_ff <= S_DONE;
            end
            S_REM_WT: state_ff <= S_REM_W1;
            S_REM_W1: begin
               if (nl_rd == NIL) tail_ff <= pl_rd;
               if (pl_rd == NIL) head_ff <= nl_rd;
               rsp_ff.value_out <= vl_rd; rsp_ff.ok <= 1'b1;
               state_ff <= S_REM_W2;
            end
            S_REM_W2: begin
               inl_ff[tgt_ff[IDX_W-1:0]] <= 1'b0; free_ff <= tgt_ff;
               state_ff <= S_DONE;
            end
            S_DONE: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_v_ff;
   assign rsp_data = rsp_ff;

   `PSLL_ASSERT_NXT(a_start_leaves_idle, clock, reset, start && !busy, busy,
      "accepted request did not start work")
   `PSLL_ASSERT_IMP(a_rsp_only_idle, clock, reset, rsp_valid, !busy,
      "result strobed while busy")
   `PSLL_ASSERT_IMP(a_ok_node, clock, reset, rsp_valid && rsp_data.node_out != NIL,
      rsp_data.ok, "node handed out without ok")
endmodule

@@ verif/tb_pooled_sorted_linked_list.sv @@
// Testbench for pooled_sorted_linked_list: directed table, then random phases per pool size.
// Depends on psll_pkg and the RTL top level; results are checked against an in-bench predictor.
`timescale 1ns / 1ps
module tb_pooled_sorted_linked_list;
   import psll_pkg::*;

   localparam logic [2:0] REQ_SPARE_LO = 3'd6;
   localparam logic [2:0] REQ_SPARE_HI = 3'd7;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int RANDOM_ITEMS = 950;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type_type req_data;
   logic csr_we;
   logic [6:0] csr_wdata;
   logic rsp_valid;
   rsp_type rsp_data;

   pooled_sorted_linked_list i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   // shadow of the pool
   logic [6:0] nxt_link [POOL_SIZE];
   logic [6:0] prv_link [POOL_SIZE];
   logic signed [31:0] node_pri [POOL_SIZE];
   logic signed [31:0] node_val [POOL_SIZE];
   bit on_list [POOL_SIZE];
   logic [6:0] list_first, list_last, free_top, pool_count;

   rsp_type pending_rsp [$];
   int n_results, n_errors, n_sent, n_cycles, n_exhausted, n_removed;

   // rebuild of the free chain from the pool count
   function automatic void pool_rebuild();
      int lim;
      lim = (pool_count > POOL_SIZE) ? POOL_SIZE : pool_count;
      list_first = NIL;
      list_last = NIL;
      free_top = NIL;
      for (int i = 0; i < POOL_SIZE; i++) on_list[i] = 0;
      for (int i = 0; i < lim; i++) begin
         nxt_link[i] = free_top;
         free_top = 7'(i);
      end
   endfunction

   function automatic logic [6:0] grab_node(logic signed [31:0] v, logic signed [31:0] p);
      logic [6:0] n;
      n = free_top;
      if (n == NIL) return NIL;
      free_top = nxt_link[n];
      node_val[n] = v;
      node_pri[n] = p;
      on_list[n] = 1;
      return n;
   endfunction

   function automatic logic [6:0] link_front(logic signed [31:0] v, logic signed [31:0] p);
      logic [6:0] n;
      n = grab_node(v, p);
      if (n == NIL) return NIL;
      nxt_link[n] = list_first;
      prv_link[n] = NIL;
      if (list_first == NIL) list_last = n;
      else prv_link[list_first] = n;
      list_first = n;
      return n;
   endfunction

   function automatic logic [6:0] link_back(logic signed [31:0] v, logic signed [31:0] p);
      logic [6:0] n;
      n = grab_node(v, p);
      if (n == NIL) return NIL;
      nxt_link[n] = NIL;
      prv_link[n] = list_last;
      if (list_last == NIL) list_first = n;
      else nxt_link[list_last] = n;
      list_last = n;
      return n;
   endfunction

   // a missing or unlinked target falls back to the front
   function automatic logic [6:0] link_before(logic [6:0] tgt, logic signed [31:0] v,
                                              logic signed [31:0] p);
      logic [6:0] n, pv;
      if (tgt >= NIL || !on_list[tgt]) return link_front(v, p);
      n = grab_node(v, p);
      if (n == NIL) return NIL;
      pv = prv_link[tgt];
      prv_link[n] = pv;
      nxt_link[n] = tgt;
      prv_link[tgt] = n;
      if (pv >= NIL) list_first = n;
      else nxt_link[pv] = n;
      return n;
   endfunction

   function automatic logic [6:0] link_sorted(logic signed [31:0] v, logic signed [31:0] p);
      logic [6:0] cur;
      int steps;
      cur = list_first;
      steps = 0;
      while (cur < NIL && steps < POOL_SIZE) begin
         if (node_pri[cur] >= p) return link_before(cur, v, p);
         cur = nxt_link[cur];
         steps++;
      end
      return link_back(v, p);
   endfunction

   // expected response for one accepted request, updating the shadow
   function automatic rsp_type list_predict(req_type_type r);
      rsp_type o;
      logic [6:0] t, nx, pv;
      o.node_out = NIL;
      o.ok = 0;
      o.value_out = 0;
      t = r.node;
      case (r.req_type)
         REQ_FRONT:  o.node_out = link_front(r.value, 0);
         REQ_BACK:   o.node_out = link_back(r.value, 0);
         REQ_BEFORE: o.node_out = link_before(t, r.value, 0);
         REQ_SORTED: o.node_out = link_sorted(r.value, r.priority_req);
         REQ_REMOVE: begin
            if (t < NIL && on_list[t]) begin
               nx = nxt_link[t];
               pv = prv_link[t];
               o.value_out = node_val[t];
               if (nx < NIL) prv_link[nx] = pv;
               else list_last = pv;
               if (pv < NIL) nxt_link[pv] = nx;
               else list_first = nx;
               on_list[t] = 0;
               nxt_link[t] = free_top;
               free_top = t;
               o.ok = 1;
            end
         end
         REQ_REBUILD: begin
            pool_rebuild();
            o.ok = 1;
         end
         default: ;
      endcase
      if (r.req_type <= REQ_SORTED) begin
         o.ok = (o.node_out != NIL);
         if (!o.ok) n_exhausted++;
      end
      if (r.req_type == REQ_REMOVE && o.ok) n_removed++;
      return o;
   endfunction

   // clock and watchdog
   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      n_cycles <= n_cycles + 1;
      if (n_cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  n_cycles, pending_rsp.size());
         $display("tb_pooled_sorted_linked_list: FAIL");
         $finish;
      end
   end

   // response checker: one strobed transfer per cycle, compared with the oldest expectation
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid) begin
         n_results++;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected response node %0d ok %0d value %0d", $time,
                     rsp_data.node_out, rsp_data.ok, rsp_data.value_out);
            n_errors++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (exp_rsp.node_out !== rsp_data.node_out) begin
               $display("%0t: node_out expected %0d actual %0d", $time,
                        exp_rsp.node_out, rsp_data.node_out);
               n_errors++;
            end
            if (exp_rsp.ok !== rsp_data.ok) begin
               $display("%0t: ok expected %0d actual %0d", $time, exp_rsp.ok, rsp_data.ok);
               n_errors++;
            end
            if (exp_rsp.value_out !== rsp_data.value_out) begin
               $display("%0t: value_out expected %0d actual %0d", $time,
                        exp_rsp.value_out, rsp_data.value_out);
               n_errors++;
            end
         end
      end
   end

   // one request transfer; typed expectation replaces the predicted one when given
   task automatic send_req(req_type_type r, bit has_typed, rsp_type typed, int gap);
      rsp_type p;
      start <= 1;
      req_data <= r;
      do @(posedge clock); while (busy);
      p = list_predict(r);
      pending_rsp.push_back(has_typed ? typed : p);
      n_sent++;
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // wait until every response is in, then let the block settle
   task automatic drain();
      start <= 0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_count(logic [6:0] v);
      drain();
      csr_we <= 1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      pool_count = v;
   endtask

   function automatic req_type_type mk_req(logic [2:0] k, logic [6:0] n,
                                           logic signed [31:0] p, logic signed [31:0] v);
      req_type_type r;
      r.req_type = k;
      r.node = n;
      r.priority_req = p;
      r.value = v;
      return r;
   endfunction

   function automatic rsp_type mk_rsp(logic [6:0] n, logic k, logic signed [31:0] v);
      rsp_type o;
      o.node_out = n;
      o.ok = k;
      o.value_out = v;
      return o;
   endfunction

   // target handle: mostly a linked node, otherwise anything the field allows
   function automatic logic [6:0] pick_target();
      logic [6:0] c;
      if ($urandom_range(0, 9) < 8) begin
         for (int i = 0; i < 12; i++) begin
            c = 7'($urandom_range(0, POOL_SIZE - 1));
            if (on_list[c]) return c;
         end
      end
      return 7'($urandom_range(0, 127));
   endfunction

   function automatic int pick_gap(bit quiet);
      int g;
      g = $urandom_range(0, 99);
      if (quiet || g < 50) return 0;
      if (g < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   typedef struct {
      bit is_cfg;
      logic [6:0] cfg_val;
      req_type_type r;
      bit has_typed;
      rsp_type typed;
   } stim_row_type;

   stim_row_type stim_table [$];

   task automatic add_row(req_type_type r, bit has_typed, rsp_type typed);
      stim_row_type s;
      s.is_cfg = 0;
      s.cfg_val = 0;
      s.r = r;
      s.has_typed = has_typed;
      s.typed = typed;
      stim_table.push_back(s);
   endtask

   task automatic add_cfg(logic [6:0] v);
      stim_row_type s;
      s.is_cfg = 1;
      s.cfg_val = v;
      s.has_typed = 0;
      stim_table.push_back(s);
   endtask

   initial begin
      rsp_type none_rsp, fail_rsp, rebuilt;
      req_type_type r;
      int kind, phase, in_phase;
      bit quiet;
      logic signed [31:0] pr;

      reset = 1;
      start = 0;
      csr_we = 0;
      csr_wdata = 0;
      req_data = '0;
      n_cycles = 0;
      n_results = 0;
      n_errors = 0;
      n_sent = 0;
      n_exhausted = 0;
      n_removed = 0;
      for (int i = 0; i < POOL_SIZE; i++) begin
         prv_link[i] = 0;
         node_pri[i] = 0;
         node_val[i] = 0;
         nxt_link[i] = (i == 0) ? NIL : 7'(i - 1);
      end
      pool_count = 7'd64;
      pool_rebuild();

      none_rsp = mk_rsp(NIL, 0, 0);
      fail_rsp = mk_rsp(NIL, 0, 0);
      rebuilt = mk_rsp(NIL, 1, 0);

      // directed: ends, fallbacks, sorted extremes, removes, unknown codes, pool sizes
      add_row(mk_req(REQ_REMOVE, NIL, 0, 0), 1, none_rsp);
      add_row(mk_req(REQ_FRONT, 0, 0, 32'sh7fffffff), 1, mk_rsp(7'd63, 1, 0));
      add_row(mk_req(REQ_BACK, 0, 0, 32'sh80000000), 1, mk_rsp(7'd62, 1, 0));
      add_row(mk_req(REQ_BEFORE, 7'd63, 0, 1), 0, none_rsp);
      add_row(mk_req(REQ_BEFORE, NIL, 0, 2), 0, none_rsp);
      add_row(mk_req(REQ_BEFORE, 7'd127, 0, 3), 0, none_rsp);
      add_row(mk_req(REQ_BEFORE, 7'd0, 0, 4), 0, none_rsp);
      add_row(mk_req(REQ_SORTED, 0, 32'sh80000000, 5), 0, none_rsp);
      add_row(mk_req(REQ_SORTED, 0, 32'sh7fffffff, 6), 0, none_rsp);
      add_row(mk_req(REQ_SORTED, 0, 0, 7), 0, none_rsp);
      add_row(mk_req(REQ_SORTED, 0, -1, 8), 0, none_rsp);
      add_row(mk_req(REQ_REMOVE, 7'd63, 0, 0), 1, mk_rsp(NIL, 1, 32'sh7fffffff));
      add_row(mk_req(REQ_REMOVE, 7'd63, 0, 0), 1, none_rsp);
      add_row(mk_req(REQ_REMOVE, 7'd127, 0, 0), 1, none_rsp);
      add_row(mk_req(REQ_SPARE_LO, 7'd5, -1, -1), 1, none_rsp);
      add_row(mk_req(REQ_SPARE_HI, 7'd127, -1, -1), 1, none_rsp);
      add_row(mk_req(REQ_REBUILD, 0, 0, 0), 1, rebuilt);
      add_cfg(7'd0);
      add_row(mk_req(REQ_REBUILD, 0, 0, 0), 1, rebuilt);
      add_row(mk_req(REQ_FRONT, 0, 0, 9), 1, fail_rsp);
      add_cfg(7'd1);
      add_row(mk_req(REQ_REBUILD, 0, 0, 0), 1, rebuilt);
      add_row(mk_req(REQ_BACK, 0, 0, -9), 1, mk_rsp(7'd0, 1, 0));
      add_row(mk_req(REQ_BEFORE, 7'd0, 0, 10), 1, fail_rsp);
      add_row(mk_req(REQ_SORTED, 0, 3, 11), 1, fail_rsp);
      add_row(mk_req(REQ_REMOVE, 7'd0, 0, 0), 1, mk_rsp(NIL, 1, -9));

      repeat (6) @(posedge clock);
      reset <= 0;

      foreach (stim_table[i]) begin
         if (stim_table[i].is_cfg) write_count(stim_table[i].cfg_val);
         else send_req(stim_table[i].r, stim_table[i].has_typed, stim_table[i].typed,
                       pick_gap(i < 6));
      end

      // random phases, each with its own pool size and a rebuild up front
      phase = 0;
      in_phase = 0;
      quiet = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (in_phase == 0) begin
            case (phase % 8)
               0: write_count(7'd64);
               1: write_count(7'd2);
               2: write_count(7'd127);
               3: write_count(7'd0);
               4: write_count(7'd1);
               default: write_count(7'($urandom_range(0, 127)));
            endcase
            send_req(mk_req(REQ_REBUILD, 0, 0, 0), 0, none_rsp, 0);
            quiet = (phase % 3 == 1);
            in_phase = $urandom_range(60, 140);
            phase++;
         end
         in_phase--;
         pr = ($urandom_range(0, 9) < 6) ? 32'($urandom_range(0, 8)) - 4 : $urandom;
         kind = $urandom_range(0, 99);
         if (kind < 15) r = mk_req(REQ_FRONT, pick_target(), pr, $urandom);
         else if (kind < 27) r = mk_req(REQ_BACK, pick_target(), pr, $urandom);
         else if (kind < 40) r = mk_req(REQ_BEFORE, pick_target(), pr, $urandom);
         else if (kind < 65) r = mk_req(REQ_SORTED, pick_target(), pr, $urandom);
         else if (kind < 97) r = mk_req(REQ_REMOVE, pick_target(), pr, $urandom);
         else if (kind < 98) r = mk_req(REQ_REBUILD, pick_target(), pr, $urandom);
         else r = mk_req($urandom_range(0, 1) ? REQ_SPARE_LO : REQ_SPARE_HI,
                         pick_target(), pr, $urandom);
         send_req(r, 0, none_rsp, pick_gap(quiet));
         // sender holds off until the block has answered everything
         if (n % 200 == 100) drain();
      end

      drain();
      $display("%0d requests sent, %0d responses checked over %0d pool-size phases",
               n_sent, n_results, phase);
      $display("%0d inserts hit an empty pool, %0d nodes removed, %0d mismatches",
               n_exhausted, n_removed, n_errors);
      if (n_errors == 0)
         $display("tb_pooled_sorted_linked_list: PASS");
      else
         $display("tb_pooled_sorted_linked_list: FAIL");
      $finish;
   end
endmodule
